FILE: rtl/ntef_pkg.sv
// Shared types and constants of the nearest-target EMA filter.
`timescale 1ns / 1ps

package ntef_pkg;

	localparam int RANGE_W    = 13;
	localparam int ALPHA_W    = 9;
	localparam int MASK_W     = 3;
	localparam int CH_FIELD_W = 2;
	localparam int CH_IDX_W   = 3;
	localparam int ALPHA_SHIFT = 8;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

	localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 9'd51;
	localparam logic [RANGE_W-1:0] RANGE_MIN_RESET = 13'd1;
	localparam logic [RANGE_W-1:0] RANGE_MAX_RESET = 13'd6000;
	localparam logic [MASK_W-1:0]  ENABLE_RESET    = 3'b111;

	localparam logic [1:0] REG_ALPHA     = 2'd0;
	localparam logic [1:0] REG_RANGE_MIN = 2'd1;
	localparam logic [1:0] REG_RANGE_MAX = 2'd2;
	localparam logic [1:0] REG_ENABLE    = 2'd3;

	typedef struct packed {
		logic [CH_FIELD_W-1:0] channel;
		logic [7:0]            target_status;
		logic signed [15:0]    range_mm;
		logic                  last_target;
	} ntef_target_t;

	typedef struct packed {
		logic [CH_FIELD_W-1:0] out_channel;
		logic [RANGE_W-1:0]    filtered_mm;
		logic [RANGE_W-1:0]    raw_mm;
	} ntef_result_t;

	// One closed frame: channel and its nearest counted range.
	typedef struct packed {
		logic [CH_IDX_W-1:0] ch;
		logic [RANGE_W-1:0]  raw;
	} ntef_frame_t;

endpackage

FILE: rtl/ntef_filter_core.sv
// Per-channel EMA read-modify-write pipeline around the filter memory.
`timescale 1ns / 1ps

module ntef_filter_core #(
	parameter int CHANNELS  = 3,
	parameter int FRAC_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ntef_pkg::ALPHA_W-1:0] alpha_q8,
	input  logic                         frame_valid,
	output logic                         frame_stall,
	input  ntef_pkg::ntef_frame_t        frame,
	output logic                         result_valid,
	input  logic                         result_stall,
	output ntef_pkg::ntef_result_t       result
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SW   = ntef_pkg::RANGE_W + FRAC_BITS;
	localparam int DW   = SW + 1;
	localparam int PW   = DW + ntef_pkg::ALPHA_W + 1;

	logic [SW-1:0]   filt_mem [CHANNELS];
	logic [SW-1:0]   mem_rd_q;
	logic [CHANNELS-1:0] seeded_q;

	logic            wr_vld_q;
	logic [CH_W-1:0] wr_ch_q;
	logic [SW-1:0]   wr_data_q;

	logic                           s1_vld;
	logic [CH_W-1:0]                ch_s1;
	logic [ntef_pkg::RANGE_W-1:0]   raw_s1;

	logic                           s2_vld;
	logic [CH_W-1:0]                ch_s2;
	logic [ntef_pkg::RANGE_W-1:0]   raw_s2;
	logic [SW-1:0]                  filt_s2;
	logic signed [PW-1:0]           prod_s2;
	logic                           seed_s2;

	logic                           out_vld_q;
	ntef_pkg::ntef_result_t         out_q;

	logic out_free, s2_free, hazard, s1_move, s1_free, s1_load, s2_move;
	logic [CH_W-1:0]              frame_idx, rd_idx;
	logic [SW-1:0]                filt_cur, filt_new, raw_fix, lo_bound, hi_bound;
	logic                         seeded_cur;
	logic [ntef_pkg::ALPHA_W-1:0] alpha_eff;
	logic signed [DW-1:0]         diff;
	logic signed [PW-1:0]         prod, step, sum;
	logic                         in_bounds;

	// Handshake between stages
	assign out_free    = !out_vld_q || !result_stall;
	assign s2_free     = !s2_vld || out_free;
	assign hazard      = s1_vld && s2_vld && (ch_s1 == ch_s2);
	assign s1_move     = s1_vld && s2_free && !hazard;
	assign s1_free     = !s1_vld || s1_move;
	assign frame_stall = !s1_free;
	assign s1_load     = frame_valid && s1_free;
	assign s2_move     = s2_vld && out_free;

	assign frame_idx = CH_W'(frame.ch);
	assign rd_idx    = s1_load ? frame_idx : ch_s1;

	// Stage 1: pick the newest filter value, form the weighted step
	assign filt_cur   = (wr_vld_q && wr_ch_q == ch_s1) ? wr_data_q : mem_rd_q;
	assign seeded_cur = seeded_q[ch_s1];
	assign alpha_eff  = (alpha_q8 > ntef_pkg::ALPHA_ONE) ? ntef_pkg::ALPHA_ONE : alpha_q8;
	assign diff = $signed({1'b0, raw_s1, {FRAC_BITS{1'b0}}}) - $signed({1'b0, filt_cur});
	assign prod = $signed({1'b0, alpha_eff}) * diff;

	// Stage 2: floor shift and add, or seed
	assign raw_fix  = {raw_s2, {FRAC_BITS{1'b0}}};
	assign step     = prod_s2 >>> ntef_pkg::ALPHA_SHIFT;
	assign sum      = $signed({{(PW-SW){1'b0}}, filt_s2}) + step;
	assign filt_new = seed_s2 ? raw_fix : sum[SW-1:0];

	assign lo_bound  = (filt_s2 < raw_fix) ? filt_s2 : raw_fix;
	assign hi_bound  = (filt_s2 < raw_fix) ? raw_fix : filt_s2;
	assign in_bounds = (filt_new >= lo_bound) && (filt_new <= hi_bound);

	always_ff @(posedge clk) begin
		if (s2_move) begin
			filt_mem[ch_s2] <= filt_new;
		end
		mem_rd_q <= filt_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld    <= 1'b0;
			s2_vld    <= 1'b0;
			out_vld_q <= 1'b0;
			wr_vld_q  <= 1'b0;
			seeded_q  <= '0;
		end else begin
			if (s1_load) begin
				s1_vld <= 1'b1;
			end else if (s1_move) begin
				s1_vld <= 1'b0;
			end
			if (s1_move) begin
				s2_vld <= 1'b1;
			end else if (s2_move) begin
				s2_vld <= 1'b0;
			end
			if (s2_move) begin
				out_vld_q <= 1'b1;
			end else if (!result_stall) begin
				out_vld_q <= 1'b0;
			end
			if (s2_move) begin
				wr_vld_q          <= 1'b1;
				seeded_q[ch_s2]   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			ch_s1  <= frame_idx;
			raw_s1 <= frame.raw;
		end
		if (s1_move) begin
			ch_s2   <= ch_s1;
			raw_s2  <= raw_s1;
			filt_s2 <= filt_cur;
			prod_s2 <= prod;
			seed_s2 <= !seeded_cur;
		end
		if (s2_move) begin
			wr_ch_q           <= ch_s2;
			wr_data_q         <= filt_new;
			out_q.out_channel <= ntef_pkg::CH_FIELD_W'(ch_s2);
			out_q.filtered_mm <= filt_new[SW-1:FRAC_BITS];
			out_q.raw_mm      <= raw_s2;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move && s2_vld |-> ch_s1 != ch_s2)
		else $error("filter update overtook a pending write of the same channel");

	a_update_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		s2_vld && !seed_s2 |-> in_bounds)
		else $error("filter update left the span between old value and raw range");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(s2_vld))
		else $error("result appeared without a finished update");

	a_seed_marked: assert property (@(posedge clk) disable iff (!arst_n)
		s2_move |=> seeded_q[$past(ch_s2)])
		else $error("written channel not marked as seeded");

endmodule

FILE: rtl/nearest_target_ema_filter.sv
// Top level of the nearest-target EMA filter: registers, frame accumulator, filter core.
`timescale 1ns / 1ps

// Nearest-target EMA filter. Each accepted item is one target record of a
// multi-target ranging frame for one channel. A record counts when its status
// is zero and its range is non-negative and within [range_min, range_max];
// the nearest counted range is held in a single frame accumulator shared by
// all channels. On the record that carries last_target, if a counted range
// exists, the channel's smoothed distance (unsigned Q13.FRAC_BITS, one entry
// per channel in a small synchronous memory) is seeded or updated as
// filt += floor(alpha*(raw - filt) / 256) and one result item is produced;
// alpha above 256 acts as 256. Records of a disabled or nonexistent channel
// are dropped without touching the accumulator. Rate: one item per cycle
// when not stalled. A result passes the memory read, multiply and output
// registers after its last record. Two frame ends of the same channel
// that would meet in the read-modify-write of the filter memory stall the
// later one until the earlier write is done; a stalled result holds the
// pipeline behind it. Registers sit at byte addresses 0 (alpha_q8), 4
// (range_min), 8 (range_max), 12 (enable_mask); write them only while the
// block is idle.
module nearest_target_ema_filter #(
	parameter int CHANNELS  = 3,
	parameter int FRAC_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [3:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   target_valid,
	output logic                   target_stall,
	input  ntef_pkg::ntef_target_t target,
	output logic                   result_valid,
	input  logic                   result_stall,
	output ntef_pkg::ntef_result_t result
);

	localparam logic [3:0] CH_COUNT = 4'(CHANNELS);

	// Configuration registers
	logic [ntef_pkg::ALPHA_W-1:0] alpha_q;
	logic [ntef_pkg::RANGE_W-1:0] range_min_q;
	logic [ntef_pkg::RANGE_W-1:0] range_max_q;
	logic [ntef_pkg::MASK_W-1:0]  enable_q;

	// Frame accumulator
	logic [ntef_pkg::RANGE_W-1:0] best_q;
	logic                         found_q;

	logic                         cfg_wr;
	logic                         accept;
	logic                         ch_ok, ch_en, active, counted, take;
	logic [3:0]                   mask_ext;
	logic [14:0]                  mag;
	logic [ntef_pkg::RANGE_W-1:0] best_next;
	logic                         found_next;
	logic                         frame_valid, frame_stall;
	ntef_pkg::ntef_frame_t        frame;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= ntef_pkg::ALPHA_RESET;
			range_min_q <= ntef_pkg::RANGE_MIN_RESET;
			range_max_q <= ntef_pkg::RANGE_MAX_RESET;
			enable_q    <= ntef_pkg::ENABLE_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				ntef_pkg::REG_ALPHA:     alpha_q     <= pwdata[ntef_pkg::ALPHA_W-1:0];
				ntef_pkg::REG_RANGE_MIN: range_min_q <= pwdata[ntef_pkg::RANGE_W-1:0];
				ntef_pkg::REG_RANGE_MAX: range_max_q <= pwdata[ntef_pkg::RANGE_W-1:0];
				ntef_pkg::REG_ENABLE:    enable_q    <= pwdata[ntef_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			ntef_pkg::REG_ALPHA:     prdata = 32'(alpha_q);
			ntef_pkg::REG_RANGE_MIN: prdata = 32'(range_min_q);
			ntef_pkg::REG_RANGE_MAX: prdata = 32'(range_max_q);
			ntef_pkg::REG_ENABLE:    prdata = 32'(enable_q);
			default:                 prdata = '0;
		endcase
	end

	// Drop records of channels that do not exist or are switched off
	assign mask_ext = {1'b0, enable_q};
	assign ch_ok    = {2'b00, target.channel} < CH_COUNT;
	assign ch_en    = mask_ext[target.channel];
	assign active   = ch_ok && ch_en;

	// Count a record with good status and a range inside the window
	assign mag     = target.range_mm[14:0];
	assign counted = (target.target_status == 8'd0) && !target.range_mm[15]
		&& (mag >= 15'(range_min_q)) && (mag <= 15'(range_max_q));
	assign take       = counted && (!found_q || mag[12:0] < best_q);
	assign best_next  = take ? mag[12:0] : best_q;
	assign found_next = found_q || counted;

	// Close the frame into the filter core when a nearest range exists
	assign frame_valid  = target_valid && active && target.last_target && found_next;
	assign frame.ch     = ntef_pkg::CH_IDX_W'(target.channel);
	assign frame.raw    = best_next;
	assign target_stall = frame_stall;
	assign accept       = target_valid && !target_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q  <= '0;
			found_q <= 1'b0;
		end else if (accept && active) begin
			if (target.last_target) begin
				best_q  <= '0;
				found_q <= 1'b0;
			end else begin
				best_q  <= best_next;
				found_q <= found_next;
			end
		end
	end

	ntef_filter_core #(
		.CHANNELS  (CHANNELS),
		.FRAC_BITS (FRAC_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.alpha_q8     (alpha_q),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.frame        (frame),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_found_empty_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && active && target.last_target |=> !found_q && best_q == '0)
		else $error("frame accumulator not cleared after a last record");

	a_best_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		accept && active && !target.last_target && take |=> found_q)
		else $error("counted record did not mark the frame as found");

	a_drop_keeps_acc: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !active |=> $stable(best_q) && $stable(found_q))
		else $error("dropped record changed the frame accumulator");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the nearest-target EMA filter: random records, APB setup, scoreboard.
`timescale 1ns / 1ps

module testbench;

	localparam int NUM_CH   = 3;
	localparam int FRAC     = 8;
	localparam int SMOOTH_W = ntef_pkg::RANGE_W + FRAC;
	// Idle cycles after the last owed result so the pipe is empty before
	// the registers change.
	localparam int SETTLE   = 8;

	// Tracks the register settings, the shared frame accumulator and the
	// per-channel smoothed distance, and holds the results still owed.
	class ema_tracker;
		logic [ntef_pkg::ALPHA_W-1:0] alpha_q8;
		logic [ntef_pkg::RANGE_W-1:0] rmin;
		logic [ntef_pkg::RANGE_W-1:0] rmax;
		logic [ntef_pkg::MASK_W-1:0]  ch_enable;
		logic [ntef_pkg::RANGE_W-1:0] best_mm;
		bit                           best_ok;
		logic [SMOOTH_W-1:0]          smooth_q [NUM_CH];
		bit                           primed [NUM_CH];
		ntef_pkg::ntef_result_t       pending_results [$];
		int                           mismatches;

		function new();
			alpha_q8   = ntef_pkg::ALPHA_RESET;
			rmin       = ntef_pkg::RANGE_MIN_RESET;
			rmax       = ntef_pkg::RANGE_MAX_RESET;
			ch_enable  = ntef_pkg::ENABLE_RESET;
			best_mm    = '0;
			best_ok    = 1'b0;
			mismatches = 0;
			for (int c = 0; c < NUM_CH; c++) begin
				smooth_q[c] = '0;
				primed[c]   = 1'b0;
			end
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] word);
			case (idx)
				ntef_pkg::REG_ALPHA:     alpha_q8  = word[ntef_pkg::ALPHA_W-1:0];
				ntef_pkg::REG_RANGE_MIN: rmin      = word[ntef_pkg::RANGE_W-1:0];
				ntef_pkg::REG_RANGE_MAX: rmax      = word[ntef_pkg::RANGE_W-1:0];
				ntef_pkg::REG_ENABLE:    ch_enable = word[ntef_pkg::MASK_W-1:0];
				default: ;
			endcase
		endfunction

		// Advance the state by one accepted record; queue a result when a
		// frame closes with a counted target.
		function void take_record(ntef_pkg::ntef_target_t rec);
			int                           ch;
			int                           mm;
			int                           weight;
			longint                       diff;
			longint                       sum;
			logic [ntef_pkg::RANGE_W-1:0] raw;
			logic [SMOOTH_W-1:0]          filt;
			ntef_pkg::ntef_result_t       res;
			ch = int'(rec.channel);
			if (ch >= NUM_CH || !ch_enable[ch])
				return;
			mm = int'($signed(rec.range_mm));
			if (rec.target_status == 8'd0 && mm >= int'(rmin) && mm <= int'(rmax) &&
			    (!best_ok || mm < int'(best_mm))) begin
				best_mm = mm[ntef_pkg::RANGE_W-1:0];
				best_ok = 1'b1;
			end
			if (!rec.last_target)
				return;
			if (!best_ok) begin
				best_mm = '0;
				return;
			end
			raw     = best_mm;
			best_mm = '0;
			best_ok = 1'b0;
			if (!primed[ch]) begin
				filt       = SMOOTH_W'(raw) << FRAC;
				primed[ch] = 1'b1;
			end else begin
				weight = (alpha_q8 > ntef_pkg::ALPHA_ONE) ? int'(ntef_pkg::ALPHA_ONE)
				                                          : int'(alpha_q8);
				diff   = (longint'(raw) <<< FRAC) - longint'(smooth_q[ch]);
				sum    = longint'(smooth_q[ch])
				         + ((longint'(weight) * diff) >>> ntef_pkg::ALPHA_SHIFT);
				filt   = sum[SMOOTH_W-1:0];
			end
			smooth_q[ch]    = filt;
			res.out_channel = rec.channel;
			res.filtered_mm = filt[SMOOTH_W-1:FRAC];
			res.raw_mm      = raw;
			pending_results.push_back(res);
		endfunction

		task report_mismatch(string what);
			$display("[%0t] mismatch: %s", $time, what);
			mismatches++;
		endtask

		task check_result(ntef_pkg::ntef_result_t got);
			ntef_pkg::ntef_result_t want;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result ch %0d filt %0d raw %0d",
					got.out_channel, got.filtered_mm, got.raw_mm));
				return;
			end
			want = pending_results.pop_front();
			if (got.out_channel !== want.out_channel)
				report_mismatch($sformatf("out_channel %0d, want %0d",
					got.out_channel, want.out_channel));
			if (got.filtered_mm !== want.filtered_mm)
				report_mismatch($sformatf("filtered_mm %0d, want %0d (ch %0d)",
					got.filtered_mm, want.filtered_mm, want.out_channel));
			if (got.raw_mm !== want.raw_mm)
				report_mismatch($sformatf("raw_mm %0d, want %0d (ch %0d)",
					got.raw_mm, want.raw_mm, want.out_channel));
		endtask
	endclass

	// Every input starts at a known value.
	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   psel         = 1'b0;
	logic                   penable      = 1'b0;
	logic                   pwrite       = 1'b0;
	logic [3:0]             paddr        = '0;
	logic [31:0]            pwdata       = '0;
	logic [31:0]            prdata;
	logic                   pready;
	logic                   target_valid = 1'b0;
	logic                   target_stall;
	ntef_pkg::ntef_target_t target       = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	ntef_pkg::ntef_result_t result;

	ema_tracker tracker = new();
	int         records_sent = 0;
	int         quiet_left   = 0;

	nearest_target_ema_filter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.target_valid (target_valid),
		.target_stall (target_stall),
		.target       (target),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Sample both channels at the edge. All drivers use nonblocking
	// assignments, so the values read here are the ones the block saw.
	always @(posedge clk) begin
		if (arst_n) begin
			if (target_valid && !target_stall)
				tracker.take_record(target);
			if (result_valid && !result_stall)
				tracker.check_result(result);
		end
	end

	// Idle length: mostly none, often a few cycles, now and then a long one.
	function automatic int gap_len();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return 0;
		if (sel < 88)
			return $urandom_range(1, 3);
		if (sel < 97)
			return $urandom_range(4, 12);
		return $urandom_range(13, 40);
	endfunction

	// Pick a range around the current window: inside it, on its bounds, just
	// outside, negative, or anything at all.
	function automatic logic [15:0] pick_range(int lo, int hi);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return 16'($urandom_range(lo, hi));
		if (sel < 68)
			return 16'(lo);
		if (sel < 76)
			return 16'(hi);
		if (sel < 80)
			return 16'(lo - 1);
		if (sel < 84)
			return 16'(hi + 1);
		if (sel < 90)
			return 16'($urandom_range(16'h8000, 16'hFFFF));
		return 16'($urandom);
	endfunction

	// Present one record and hold it until the block takes it.
	task automatic send_target(ntef_pkg::ntef_target_t rec);
		target       <= rec;
		target_valid <= 1'b1;
		@(posedge clk);
		while (target_stall)
			@(posedge clk);
		records_sent++;
	endtask

	// Drop valid for a random gap, except during a quiet stretch of
	// back-to-back records.
	task automatic pause_target();
		int gap;
		gap = (quiet_left > 0) ? 0 : gap_len();
		if (quiet_left > 0)
			quiet_left--;
		else if ($urandom_range(0, 49) == 0)
			quiet_left = $urandom_range(20, 60);
		if (gap > 0) begin
			target_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_directed(int ch, int status, int mm, bit last);
		ntef_pkg::ntef_target_t rec;
		rec.channel       = 2'(ch);
		rec.target_status = 8'(status);
		rec.range_mm      = 16'(mm);
		rec.last_target   = last;
		send_target(rec);
		pause_target();
	endtask

	// One frame: mostly well-formed records of one channel closed by a last
	// mark; sometimes a stray channel, a missing last mark or pure noise.
	task automatic send_frame();
		int                     ch;
		int                     len;
		ntef_pkg::ntef_target_t rec;
		ch  = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, NUM_CH - 1);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 11) == 0) begin
				rec.channel       = 2'($urandom);
				rec.target_status = 8'($urandom);
				rec.range_mm      = 16'($urandom);
				rec.last_target   = 1'($urandom);
			end else begin
				rec.channel       = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
				                                               : 2'(ch);
				rec.target_status = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
				                                               : 8'd0;
				rec.range_mm      = pick_range(int'(tracker.rmin), int'(tracker.rmax));
				rec.last_target   = (i == len - 1) && ($urandom_range(0, 14) != 0);
			end
			send_target(rec);
			pause_target();
		end
	endtask

	// Wait until every owed result is out, then let the pipe empty.
	task automatic drain();
		target_valid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; psel stays high across back-to-back
	// transfers and is dropped by the caller.
	task automatic apb_write(logic [1:0] idx, logic [31:0] word);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		tracker.write_reg(idx, word);
	endtask

	task automatic check_reg(logic [1:0] idx, logic [31:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== want)
			tracker.report_mismatch($sformatf("register %0d reads %0h, want %0h",
				idx, prdata, want));
	endtask

	// Write all registers with junk in the unused upper bits, then read
	// them back.
	task automatic configure(logic [ntef_pkg::ALPHA_W-1:0] a,
	                         logic [ntef_pkg::RANGE_W-1:0] lo,
	                         logic [ntef_pkg::RANGE_W-1:0] hi,
	                         logic [ntef_pkg::MASK_W-1:0] en);
		drain();
		apb_write(ntef_pkg::REG_ALPHA,     {23'($urandom), a});
		apb_write(ntef_pkg::REG_RANGE_MIN, {19'($urandom), lo});
		apb_write(ntef_pkg::REG_RANGE_MAX, {19'($urandom), hi});
		apb_write(ntef_pkg::REG_ENABLE,    {29'($urandom), en});
		check_reg(ntef_pkg::REG_ALPHA,     32'(a));
		check_reg(ntef_pkg::REG_RANGE_MIN, 32'(lo));
		check_reg(ntef_pkg::REG_RANGE_MAX, 32'(hi));
		check_reg(ntef_pkg::REG_ENABLE,    32'(en));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_phase(logic [ntef_pkg::ALPHA_W-1:0] a,
	                         logic [ntef_pkg::RANGE_W-1:0] lo,
	                         logic [ntef_pkg::RANGE_W-1:0] hi,
	                         logic [ntef_pkg::MASK_W-1:0] en, int count);
		int stop;
		configure(a, lo, hi, en);
		stop = records_sent + count;
		while (records_sent < stop)
			send_frame();
	endtask

	// Result side: short ready runs broken by random stalls, and now and then
	// a long stretch with no stall at all.
	initial begin : result_side
		int run;
		@(posedge clk);
		forever begin
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 4);
			result_stall <= 1'b0;
			repeat (run) @(posedge clk);
			run = gap_len();
			if (run > 0) begin
				result_stall <= 1'b1;
				repeat (run) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int a;
		int lo;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: alpha 51, window 1..6000, all channels on.
		send_directed(0, 0, 6000, 1);      // seed channel 0 at the top bound
		send_directed(0, 0, 1, 1);         // bottom bound, first real update
		send_directed(0, 0, 0, 1);         // below the window: no result
		send_directed(0, 0, 6001, 1);      // above the window: no result
		send_directed(0, 0, -1, 1);        // negative ranges never count
		send_directed(0, 0, -32768, 1);
		send_directed(0, 0, 32767, 1);
		send_directed(1, 255, 100, 0);     // bad status loses despite being nearest
		send_directed(1, 0, 300, 0);
		send_directed(1, 0, 200, 0);
		send_directed(1, 1, 50, 1);        // seed channel 1 with 200
		send_directed(2, 0, 3000, 0);
		send_directed(3, 0, 10, 1);        // nonexistent channel, last mark ignored
		send_directed(2, 0, 2000, 1);
		send_directed(0, 0, 500, 0);       // mixed frame closes on channel 1
		send_directed(1, 0, 400, 1);
		send_directed(0, 128, 100, 1);     // only a bad-status record: no result
		send_directed(2, 0, 5999, 1);
		send_directed(0, 0, 4095, 0);      // equal ranges
		send_directed(0, 0, 4095, 1);
		send_directed(1, 0, 6000, 0);
		send_directed(1, 0, 1, 1);

		run_phase(ntef_pkg::ALPHA_ONE, 13'd0, 13'd8191, 3'b111, 180); // filter follows raw
		run_phase(9'd0, 13'd100, 13'd4000, 3'b101, 150);      // frozen filter, channel 1 off
		run_phase(9'd511, 13'd1, 13'd6000, 3'b111, 150);      // alpha clamps to one
		run_phase(9'd1, 13'd8191, 13'd8191, 3'b111, 80);      // only the farthest range
		run_phase(9'd51, 13'd700, 13'd300, 3'b111, 40);       // empty window
		run_phase(9'd128, 13'd0, 13'd8191, 3'b000, 40);       // every channel off
		run_phase(9'd200, 13'd0, 13'd0, 3'b010, 60);          // zero-width window at zero
		repeat (6) begin
			a  = ($urandom_range(0, 4) == 0) ? $urandom_range(257, 511) : $urandom_range(1, 256);
			lo = $urandom_range(0, 3000);
			run_phase(9'(a), 13'(lo), 13'($urandom_range(lo, 8191)),
			          3'($urandom_range(1, 7)), 120);
		end
		run_phase(ntef_pkg::ALPHA_RESET, ntef_pkg::RANGE_MIN_RESET,
		          ntef_pkg::RANGE_MAX_RESET, ntef_pkg::ENABLE_RESET, 100);

		drain();
		if (tracker.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Hard stop far beyond the slowest correct run.
	initial begin : watchdog
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
